// ===== rtl/affine_transform_point_vector_plane_defines.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef AFFINE_TRANSFORM_POINT_VECTOR_PLANE_DEFINES_SVH
`define AFFINE_TRANSFORM_POINT_VECTOR_PLANE_DEFINES_SVH

// clocked assertion, disabled while the active-low reset is low
`define AFT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same, on the block clock and reset
`define AFT_ASSERT(label, prop, msg) \
    `AFT_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/aft_pkg.sv =====
// types, constants and fixed-point helpers for the affine transform pipeline
// no dependencies
package aft_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int CFG_W     = 2 * COORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int LATENCY   = 9;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord Q_ONE = t_coord'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        OP_POINT,
        OP_VECTOR,
        OP_NORMAL,
        OP_PLANE
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORWARD_XY,
        REG_FORWARD_Z_LEFT_X,
        REG_LEFT_YZ,
        REG_UP_XY,
        REG_UP_Z_POS_X,
        REG_POS_YZ,
        REG_SCALE
    } t_reg_idx;

    typedef struct packed {
        t_coord [2:0] fwd;
        t_coord [2:0] left;
        t_coord [2:0] up;
        t_coord [2:0] pos;
        t_coord       scale;
    } t_xform;

    typedef struct packed {
        logic valid;
        t_op  op;
        logic last;
    } t_ctl;

    function automatic t_coord sat_c(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = {{(PROD_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
        if (v > hi) begin
            sat_c = hi[COORD_W-1:0];
        end else if (v < lo) begin
            sat_c = lo[COORD_W-1:0];
        end else begin
            sat_c = v[COORD_W-1:0];
        end
    endfunction

    // exact product, floor shift, saturate
    function automatic t_coord mul_q(input t_coord a, input t_coord b);
        logic signed [PROD_W-1:0] p;
        p = a * b;
        mul_q = sat_c(p >>> FRAC_BITS);
    endfunction

    function automatic t_coord add_sat(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            add_sat = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            add_sat = s[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/aft_cfg.sv =====
// configuration register file: basis columns, position and scale
// depends on aft_pkg
module aft_cfg
    import aft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output t_xform               o_xform
);

    t_xform r_xform;
    t_coord w_lo;
    t_coord w_hi;

    assign w_lo        = i_cfg_data[COORD_W-1:0];
    assign w_hi        = i_cfg_data[CFG_W-1:COORD_W];
    assign o_cfg_ready = 1'b1;
    assign o_xform     = r_xform;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xform.fwd   <= {{(2*COORD_W){1'b0}}, Q_ONE};
            r_xform.left  <= {{COORD_W{1'b0}}, Q_ONE, {COORD_W{1'b0}}};
            r_xform.up    <= {Q_ONE, {(2*COORD_W){1'b0}}};
            r_xform.pos   <= '0;
            r_xform.scale <= Q_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FORWARD_XY: begin
                    r_xform.fwd[0] <= w_lo;
                    r_xform.fwd[1] <= w_hi;
                end
                REG_FORWARD_Z_LEFT_X: begin
                    r_xform.fwd[2]  <= w_lo;
                    r_xform.left[0] <= w_hi;
                end
                REG_LEFT_YZ: begin
                    r_xform.left[1] <= w_lo;
                    r_xform.left[2] <= w_hi;
                end
                REG_UP_XY: begin
                    r_xform.up[0] <= w_lo;
                    r_xform.up[1] <= w_hi;
                end
                REG_UP_Z_POS_X: begin
                    r_xform.up[2]  <= w_lo;
                    r_xform.pos[0] <= w_hi;
                end
                REG_POS_YZ: begin
                    r_xform.pos[1] <= w_lo;
                    r_xform.pos[2] <= w_hi;
                end
                REG_SCALE: begin
                    r_xform.scale <= w_lo;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/aft_rot.sv =====
// stages one to five: scale, basis products, saturating sums, position add
// depends on aft_pkg
module aft_rot
    import aft_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    input  t_coord [2:0] i_vec,
    input  t_coord       i_d,
    input  t_xform       i_xform,
    output t_ctl         o_ctl,
    output t_coord [2:0] o_vec,
    output t_coord       o_dterm
);

    t_ctl         r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl;
    t_coord [2:0] r1_vec;
    t_coord [2:0] r2_pf, r2_pl, r2_pu;
    t_coord [2:0] r3_sum, r3_pu;
    t_coord [2:0] r4_sum;
    t_coord [2:0] r5_vec;
    t_coord       r1_dterm, r2_dterm, r3_dterm, r4_dterm, r5_dterm;
    logic         w_scaled;

    assign w_scaled = (i_ctl.op == OP_POINT) || (i_ctl.op == OP_VECTOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_vec[k] <= w_scaled ? mul_q(i_vec[k], i_xform.scale) : i_vec[k];
            r2_pf[k]  <= mul_q(r1_vec[0], i_xform.fwd[k]);
            r2_pl[k]  <= mul_q(r1_vec[1], i_xform.left[k]);
            r2_pu[k]  <= mul_q(r1_vec[2], i_xform.up[k]);
            r3_sum[k] <= add_sat(r2_pf[k], r2_pl[k]);
            r3_pu[k]  <= r2_pu[k];
            r4_sum[k] <= add_sat(r3_sum[k], r3_pu[k]);
            r5_vec[k] <= (r4_ctl.op == OP_POINT) ? add_sat(r4_sum[k], i_xform.pos[k])
                                                 : r4_sum[k];
        end
        r1_dterm <= mul_q(i_xform.scale, i_d);
        r2_dterm <= r1_dterm;
        r3_dterm <= r2_dterm;
        r4_dterm <= r3_dterm;
        r5_dterm <= r4_dterm;
    end

    assign o_ctl   = r5_ctl;
    assign o_vec   = r5_vec;
    assign o_dterm = r5_dterm;

endmodule

// ===== rtl/aft_dist.sv =====
// stages six to nine: plane distance from position dot rotated normal
// depends on aft_pkg
module aft_dist
    import aft_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    input  t_coord [2:0] i_vec,
    input  t_coord       i_dterm,
    input  t_coord [2:0] i_pos,
    output t_ctl         o_ctl,
    output t_coord [2:0] o_vec,
    output t_coord       o_d
);

    t_ctl         r6_ctl, r7_ctl, r8_ctl, r9_ctl;
    t_coord [2:0] r6_vec, r7_vec, r8_vec, r9_vec;
    t_coord [2:0] r6_prod;
    t_coord       r6_dterm, r7_dterm, r8_dterm;
    t_coord       r7_sum, r7_p2;
    t_coord       r8_dot;
    t_coord       r9_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_ctl <= '0;
            r7_ctl <= '0;
            r8_ctl <= '0;
            r9_ctl <= '0;
        end else begin
            r6_ctl <= i_ctl;
            r7_ctl <= r6_ctl;
            r8_ctl <= r7_ctl;
            r9_ctl <= r8_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r6_prod[k] <= mul_q(i_pos[k], i_vec[k]);
        end
        r6_vec   <= i_vec;
        r7_vec   <= r6_vec;
        r8_vec   <= r7_vec;
        r9_vec   <= r8_vec;
        r6_dterm <= i_dterm;
        r7_dterm <= r6_dterm;
        r8_dterm <= r7_dterm;
        r7_sum   <= add_sat(r6_prod[0], r6_prod[1]);
        r7_p2    <= r6_prod[2];
        r8_dot   <= add_sat(r7_sum, r7_p2);
        r9_d     <= (r8_ctl.op == OP_PLANE) ? add_sat(r8_dterm, r8_dot) : '0;
    end

    assign o_ctl = r9_ctl;
    assign o_vec = r9_vec;
    assign o_d   = r9_d;

endmodule

// ===== rtl/affine_transform_point_vector_plane.sv =====
// top level of the affine point, vector, normal and plane transform unit
// depends on aft_pkg, aft_cfg, aft_rot, aft_dist
//
// usage
//   request channel: drive i_operation, i_in_x/y/z/d and i_in_last with start
//   high; a request is taken at every rising edge where start is high and busy
//   is low. busy stays low, so a new request may enter on every clock.
//   result channel: o_valid is high for one cycle with o_out_x/y/z/d and
//   o_out_last; results come out in request order and cannot be held off.
//   throughput is one transform per clock. a request passes through the
//   registered chain scale multiply, basis multiply, two saturating adds,
//   position add, plane dot multiply, two saturating adds and the final
//   distance add before its result appears.
//   configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes one
//   register; o_cfg_ready is always high. write only while no request is in
//   flight. index seven is ignored.
//   reset (i_rst_n low, synchronous) empties the pipeline and loads the
//   identity basis, zero position and unit scale.
module affine_transform_point_vector_plane
    import aft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_operation,
    input  logic [COORD_W-1:0]   i_in_x,
    input  logic [COORD_W-1:0]   i_in_y,
    input  logic [COORD_W-1:0]   i_in_z,
    input  logic [COORD_W-1:0]   i_in_d,
    input  logic                 i_in_last,
    output logic                 o_valid,
    output logic [COORD_W-1:0]   o_out_x,
    output logic [COORD_W-1:0]   o_out_y,
    output logic [COORD_W-1:0]   o_out_z,
    output logic [COORD_W-1:0]   o_out_d,
    output logic                 o_out_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_xform       w_xform;
    t_ctl         w_in_ctl;
    t_coord [2:0] w_in_vec;
    t_ctl         w_mid_ctl;
    t_coord [2:0] w_mid_vec;
    t_coord       w_mid_dterm;
    t_ctl         w_out_ctl;
    t_coord [2:0] w_out_vec;
    t_coord       w_out_d;

    assign busy           = 1'b0;
    assign w_in_ctl.valid = start && !busy;
    assign w_in_ctl.op    = t_op'(i_operation);
    assign w_in_ctl.last  = i_in_last;
    assign w_in_vec[0]    = i_in_x;
    assign w_in_vec[1]    = i_in_y;
    assign w_in_vec[2]    = i_in_z;

    aft_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_xform     (w_xform)
    );

    aft_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_in_ctl),
        .i_vec   (w_in_vec),
        .i_d     (i_in_d),
        .i_xform (w_xform),
        .o_ctl   (w_mid_ctl),
        .o_vec   (w_mid_vec),
        .o_dterm (w_mid_dterm)
    );

    aft_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mid_ctl),
        .i_vec   (w_mid_vec),
        .i_dterm (w_mid_dterm),
        .i_pos   (w_xform.pos),
        .o_ctl   (w_out_ctl),
        .o_vec   (w_out_vec),
        .o_d     (w_out_d)
    );

    assign o_valid    = w_out_ctl.valid;
    assign o_out_last = w_out_ctl.last;
    assign o_out_x    = w_out_vec[0];
    assign o_out_y    = w_out_vec[1];
    assign o_out_z    = w_out_vec[2];
    assign o_out_d    = w_out_d;

endmodule

// ===== rtl/aft_checker.sv =====
// port-level checks on request to result timing, last flag and d value, bound to the top level
// depends on aft_pkg and affine_transform_point_vector_plane_defines.svh
`include "affine_transform_point_vector_plane_defines.svh"

module aft_checker
    import aft_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         i_operation,
    input logic               i_in_last,
    input logic               o_valid,
    input logic               o_out_last,
    input logic [COORD_W-1:0] o_out_d
);

    `AFT_ASSERT(a_result_follows, start && !busy |-> ##LATENCY o_valid, "missing result")
    `AFT_ASSERT(a_no_spurious, o_valid |-> $past(start && !busy, LATENCY), "spurious result")
    `AFT_ASSERT(a_last_kept, start && !busy && i_in_last |-> ##LATENCY o_out_last, "last lost")
    `AFT_ASSERT(a_d_zero, start && !busy && (i_operation != OP_PLANE) |-> ##LATENCY (o_out_d == '0), "d not zero")

endmodule

bind affine_transform_point_vector_plane aft_checker u_aft_checker (.*);
